[rtl/led_matrix_frame_receiver_defines.svh]
// Assertion macros for the LED matrix frame receiver.
// Define ASSERT_OFF to compile the assertions out; no other dependencies.
`ifndef LED_MATRIX_FRAME_RECEIVER_DEFINES_SVH
`define LED_MATRIX_FRAME_RECEIVER_DEFINES_SVH

`ifndef ASSERT_OFF
`define LMFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmfr assertion failed");
`define LMFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmfr assertion failed");
`else
`define LMFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define LMFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/lmfr_pkg.sv]
// Types and constants shared by the LED matrix frame receiver modules.
// No dependencies.
`timescale 1ns / 1ps

package lmfr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PIX_IDX_W  = 12;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned HDR_POS_W  = 3;
  localparam int unsigned AREA_W     = 16;

  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_START = 1'b1;

  localparam logic KIND_SIZE  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  localparam logic [HDR_POS_W-1:0] HDR_POS_FIRST  = 3'd0;
  localparam logic [HDR_POS_W-1:0] HDR_POS_WIDTH  = 3'd4;
  localparam logic [HDR_POS_W-1:0] HDR_POS_HEIGHT = 3'd5;

  localparam logic [BYTE_W-1:0] HDR_TEXT [4] = '{8'h73, 8'h69, 8'h7A, 8'h65};

  localparam logic [1:0] SUB_FIRST  = 2'd0;
  localparam logic [1:0] SUB_SECOND = 2'd1;
  localparam logic [1:0] SUB_THIRD  = 2'd2;

  typedef logic [PIX_IDX_W-1:0] pix_idx_t;

  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   matrix_width;
    logic [BYTE_W-1:0]   matrix_height;
    logic                size_accepted;
    pix_idx_t            pixel_index;
    logic [COLOR_W-1:0]  pixel_color;
    logic                frame_last;
  } result_t;

endpackage

[rtl/lmfr_parser.sv]
// Header matcher, size check and pixel packer for the LED matrix frame receiver.
// Depends on lmfr_pkg.
`timescale 1ns / 1ps

module lmfr_parser #(
  parameter int unsigned MAX_PIXELS = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       beat_i,
  input  logic                       req_type_i,
  input  logic [lmfr_pkg::BYTE_W-1:0] data_byte_i,
  output logic                       res_valid_o,
  output lmfr_pkg::result_t          res_o
);

  localparam int unsigned IDX_W = $clog2(MAX_PIXELS + 1);

  logic                              hunting_q, hunting_d;
  logic [lmfr_pkg::HDR_POS_W-1:0]    hdr_pos_q, hdr_pos_d;
  logic [lmfr_pkg::BYTE_W-1:0]       width_q, width_d;
  logic [lmfr_pkg::BYTE_W-1:0]       height_q, height_d;
  logic                              active_q, active_d;
  logic [lmfr_pkg::AREA_W-1:0]       area_q, area_d;
  logic [IDX_W-1:0]                  idx_q, idx_d;
  logic [1:0]                        sub_q, sub_d;
  logic [lmfr_pkg::BYTE_W-1:0]       byte0_q, byte0_d;
  logic [lmfr_pkg::BYTE_W-1:0]       byte1_q, byte1_d;
  logic [lmfr_pkg::AREA_W-1:0]       new_area;
  logic                              size_ok;
  logic                              last;

  assign new_area = lmfr_pkg::AREA_W'(width_q) * lmfr_pkg::AREA_W'(data_byte_i);
  assign size_ok  = (new_area != '0) && (17'(new_area) <= 17'(MAX_PIXELS));
  assign last     = (17'(idx_q) + 17'd1) == 17'(area_q);

  always_comb begin
    hunting_d   = hunting_q;
    hdr_pos_d   = hdr_pos_q;
    width_d     = width_q;
    height_d    = height_q;
    active_d    = active_q;
    area_d      = area_q;
    idx_d       = idx_q;
    sub_d       = sub_q;
    byte0_d     = byte0_q;
    byte1_d     = byte1_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (beat_i) begin
      if (req_type_i == lmfr_pkg::REQ_START) begin
        hunting_d = 1'b1;
        hdr_pos_d = lmfr_pkg::HDR_POS_FIRST;
      end else if (hunting_q) begin
        if (hdr_pos_q < lmfr_pkg::HDR_POS_WIDTH) begin
          hdr_pos_d = (data_byte_i == lmfr_pkg::HDR_TEXT[hdr_pos_q[1:0]]) ?
                      hdr_pos_q + lmfr_pkg::HDR_POS_W'(1) : lmfr_pkg::HDR_POS_FIRST;
        end else if (hdr_pos_q == lmfr_pkg::HDR_POS_WIDTH) begin
          width_d   = data_byte_i;
          hdr_pos_d = lmfr_pkg::HDR_POS_HEIGHT;
        end else if (hdr_pos_q == lmfr_pkg::HDR_POS_HEIGHT) begin
          height_d  = data_byte_i;
          hdr_pos_d = lmfr_pkg::HDR_POS_FIRST;
          hunting_d = 1'b0;
          active_d  = size_ok;
          area_d    = new_area;
          idx_d     = '0;
          sub_d     = lmfr_pkg::SUB_FIRST;
          byte0_d   = '0;
          byte1_d   = '0;
          res_valid_o         = 1'b1;
          res_o.kind          = lmfr_pkg::KIND_SIZE;
          res_o.matrix_width  = width_q;
          res_o.matrix_height = data_byte_i;
          res_o.size_accepted = size_ok;
        end else begin
          hdr_pos_d = lmfr_pkg::HDR_POS_FIRST;
        end
      end else if (active_q) begin
        case (sub_q)
          lmfr_pkg::SUB_FIRST: begin
            byte0_d = data_byte_i;
            sub_d   = lmfr_pkg::SUB_SECOND;
          end
          lmfr_pkg::SUB_SECOND: begin
            byte1_d = data_byte_i;
            sub_d   = lmfr_pkg::SUB_THIRD;
          end
          default: begin
            res_valid_o       = 1'b1;
            res_o.kind        = lmfr_pkg::KIND_PIXEL;
            res_o.pixel_index = lmfr_pkg::pix_idx_t'(idx_q);
            res_o.pixel_color = {data_byte_i, byte1_q, byte0_q};
            res_o.frame_last  = last;
            idx_d             = last ? '0 : idx_q + IDX_W'(1);
            sub_d             = lmfr_pkg::SUB_FIRST;
            byte0_d           = '0;
            byte1_d           = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunting_q <= 1'b1;
      hdr_pos_q <= lmfr_pkg::HDR_POS_FIRST;
      width_q   <= '0;
      height_q  <= '0;
      active_q  <= 1'b0;
      area_q    <= '0;
      idx_q     <= '0;
      sub_q     <= lmfr_pkg::SUB_FIRST;
    end else begin
      hunting_q <= hunting_d;
      hdr_pos_q <= hdr_pos_d;
      width_q   <= width_d;
      height_q  <= height_d;
      active_q  <= active_d;
      area_q    <= area_d;
      idx_q     <= idx_d;
      sub_q     <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte0_q <= byte0_d;
    byte1_q <= byte1_d;
  end

endmodule

[rtl/led_matrix_frame_receiver.sv]
// LED matrix frame receiver top level: parser plus two-entry result buffer.
// Depends on lmfr_pkg, lmfr_parser and led_matrix_frame_receiver_defines.svh.
//
// Input channel: one beat per serial byte (req_type 0) or start-new-matrix
// event (req_type 1), taken when in_valid_i is high and in_stall_o is low.
// The block hunts for the header "size", then takes width and height bytes and
// returns a size report; after an accepted size every three data bytes give a
// pixel beat with its index and a frame_last mark.
// Output channel: one beat per result, taken when out_valid_o is high and
// out_stall_i is low. Only size reports and third pixel bytes give results.
// Throughput: one input beat per cycle while in_stall_o is low.
// The parser's result is combinational; the block registers it before presenting it.
// A result register plus a skid register hold up to two results; in_stall_o
// rises only while the skid register is full, so input keeps flowing while one
// finished result waits on a stalled receiver.
// Reset (rst_ni low, asynchronous): hunting for the header, no accepted size,
// output empty.
`timescale 1ns / 1ps
`include "led_matrix_frame_receiver_defines.svh"

module led_matrix_frame_receiver #(
  parameter int unsigned MAX_PIXELS = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [lmfr_pkg::BYTE_W-1:0]   data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          result_kind_o,
  output logic [lmfr_pkg::BYTE_W-1:0]   matrix_width_o,
  output logic [lmfr_pkg::BYTE_W-1:0]   matrix_height_o,
  output logic                          size_accepted_o,
  output lmfr_pkg::pix_idx_t            pixel_index_o,
  output logic [lmfr_pkg::COLOR_W-1:0]  pixel_color_o,
  output logic                          frame_last_o
);

  logic              in_beat;
  logic              out_take;
  logic              res_valid;
  lmfr_pkg::result_t res;
  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  lmfr_pkg::result_t out_q, out_d;
  lmfr_pkg::result_t skid_q, skid_d;

  assign in_stall_o = skid_valid_q;
  assign in_beat    = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  lmfr_parser #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (in_beat),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_q.kind;
  assign matrix_width_o  = out_q.matrix_width;
  assign matrix_height_o = out_q.matrix_height;
  assign size_accepted_o = out_q.size_accepted;
  assign pixel_index_o   = out_q.pixel_index;
  assign pixel_color_o   = out_q.pixel_color;
  assign frame_last_o    = out_q.frame_last;

  `LMFR_ASSERT_IMPL(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `LMFR_ASSERT_NEXT(a_stalled_result_to_skid, clk_i, rst_ni,
                    res_valid && out_valid_q && out_stall_i, skid_valid_q)
  `LMFR_ASSERT_IMPL(a_size_report_clean, clk_i, rst_ni,
                    out_valid_o && (result_kind_o == lmfr_pkg::KIND_SIZE),
                    (pixel_index_o == '0) && (pixel_color_o == '0) && !frame_last_o)

endmodule

[bench/lmfr_frame_checker.sv]
// Scoreboard for the LED matrix frame receiver: watches both channels, tracks
// header, size and pixel assembly, and compares every result beat in order.
// Depends on lmfr_pkg.
`timescale 1ns / 1ps

module lmfr_frame_checker
  import lmfr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 req_type_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic                 result_kind_i,
  input  logic [BYTE_W-1:0]    matrix_width_i,
  input  logic [BYTE_W-1:0]    matrix_height_i,
  input  logic                 size_accepted_i,
  input  pix_idx_t             pixel_index_i,
  input  logic [COLOR_W-1:0]   pixel_color_i,
  input  logic                 frame_last_i,
  output int                   errors_o,
  output int                   pending_o
);

  localparam int unsigned PIXEL_LIMIT = 4096;

  logic                 hunting;
  logic [HDR_POS_W-1:0] hdr_pos;
  logic [BYTE_W-1:0]    frame_w;
  logic [BYTE_W-1:0]    frame_h;
  logic                 active;
  logic [13:0]          byte_pos;
  logic [15:0]          partial;

  result_t expected_q[$];
  int      fail_count = 0;

  function automatic bit decode_beat(input logic req, input logic [BYTE_W-1:0] b,
                                     output result_t r);
    int unsigned area;
    int unsigned idx;
    int unsigned sub;
    bit          ok;
    bit          last;
    r = '0;
    if (req == REQ_START) begin
      hunting = 1'b1;
      hdr_pos = HDR_POS_FIRST;
      return 1'b0;
    end
    if (hunting) begin
      if (hdr_pos < HDR_POS_WIDTH) begin
        hdr_pos = (b == HDR_TEXT[hdr_pos[1:0]]) ? hdr_pos + 3'd1 : HDR_POS_FIRST;
        return 1'b0;
      end
      if (hdr_pos == HDR_POS_WIDTH) begin
        frame_w = b;
        hdr_pos = HDR_POS_HEIGHT;
        return 1'b0;
      end
      if (hdr_pos == HDR_POS_HEIGHT) begin
        frame_h  = b;
        hdr_pos  = HDR_POS_FIRST;
        hunting  = 1'b0;
        area     = 32'(frame_w) * 32'(frame_h);
        ok       = (area != 0) && (area <= PIXEL_LIMIT);
        active   = ok;
        byte_pos = '0;
        partial  = '0;
        r.kind          = KIND_SIZE;
        r.matrix_width  = frame_w;
        r.matrix_height = frame_h;
        r.size_accepted = ok;
        return 1'b1;
      end
      hdr_pos = HDR_POS_FIRST;
      return 1'b0;
    end
    if (!active) begin
      return 1'b0;
    end
    area = 32'(frame_w) * 32'(frame_h);
    idx  = 32'(byte_pos) / 3;
    sub  = 32'(byte_pos) % 3;
    if (idx >= area) begin
      byte_pos = '0;
      partial  = '0;
      idx      = 0;
      sub      = 0;
    end
    if (sub == 32'(SUB_FIRST)) begin
      partial  = {8'h00, b};
      byte_pos = byte_pos + 14'd1;
      return 1'b0;
    end
    if (sub == 32'(SUB_SECOND)) begin
      partial[15:8] = b;
      byte_pos      = byte_pos + 14'd1;
      return 1'b0;
    end
    last          = (idx + 1 == area);
    r.kind        = KIND_PIXEL;
    r.pixel_index = idx[PIX_IDX_W-1:0];
    r.pixel_color = {b, partial};
    r.frame_last  = last;
    partial       = '0;
    byte_pos      = last ? 14'd0 : byte_pos + 14'd1;
    return 1'b1;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    result_t fresh;
    if (!rst_ni) begin
      hunting  = 1'b1;
      hdr_pos  = HDR_POS_FIRST;
      frame_w  = '0;
      frame_h  = '0;
      active   = 1'b0;
      byte_pos = '0;
      partial  = '0;
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, expected none, actual kind %0b",
                   $time, result_kind_i);
        end else begin
          want = expected_q.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(result_kind_i));
          check_field("matrix_width", 32'(want.matrix_width), 32'(matrix_width_i));
          check_field("matrix_height", 32'(want.matrix_height), 32'(matrix_height_i));
          check_field("size_accepted", 32'(want.size_accepted), 32'(size_accepted_i));
          check_field("pixel_index", 32'(want.pixel_index), 32'(pixel_index_i));
          check_field("pixel_color", 32'(want.pixel_color), 32'(pixel_color_i));
          check_field("frame_last", 32'(want.frame_last), 32'(frame_last_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (decode_beat(req_type_i, data_byte_i, fresh)) begin
          expected_q.push_back(fresh);
        end
      end
    end
    pending_o <= expected_q.size();
    errors_o  <= fail_count;
  end

endmodule

[bench/testbench.sv]
// Top of the LED matrix frame receiver bench: clock, reset, byte stimulus,
// receiver stalls and the verdict. Depends on lmfr_pkg, lmfr_frame_checker and the block.
`timescale 1ns / 1ps

module testbench;
  import lmfr_pkg::*;

  localparam int RANDOM_BEATS = 700;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 400000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                req_type_i;
  logic [BYTE_W-1:0]   data_byte_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                result_kind_o;
  logic [BYTE_W-1:0]   matrix_width_o;
  logic [BYTE_W-1:0]   matrix_height_o;
  logic                size_accepted_o;
  pix_idx_t            pixel_index_o;
  logic [COLOR_W-1:0]  pixel_color_o;
  logic                frame_last_o;

  int errors;
  int pending;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int beats_sent  = 0;
  int holds_asked = 0;
  int holds_done  = 0;
  int cycles      = 0;

  led_matrix_frame_receiver DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .matrix_width_o  (matrix_width_o),
    .matrix_height_o (matrix_height_o),
    .size_accepted_o (size_accepted_o),
    .pixel_index_o   (pixel_index_o),
    .pixel_color_o   (pixel_color_o),
    .frame_last_o    (frame_last_o)
  );

  lmfr_frame_checker frame_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .req_type_i      (req_type_i),
    .data_byte_i     (data_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_i   (result_kind_o),
    .matrix_width_i  (matrix_width_o),
    .matrix_height_i (matrix_height_o),
    .size_accepted_i (size_accepted_o),
    .pixel_index_i   (pixel_index_o),
    .pixel_color_i   (pixel_color_o),
    .frame_last_i    (frame_last_o),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  task automatic put_beat(input logic req, input logic [BYTE_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i  <= 1'b0;
      req_type_i  <= 1'($urandom);
      data_byte_i <= 8'($urandom);
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    data_byte_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic put_header(input logic [BYTE_W-1:0] w, input logic [BYTE_W-1:0] h,
                            input bit spoil);
    int bad_at;
    bad_at = spoil ? int'($urandom_range(3)) : 4;
    for (int k = 0; k < 4; k++) begin
      put_beat(REQ_DATA, (k == bad_at) ? 8'($urandom) : HDR_TEXT[k]);
    end
    put_beat(REQ_DATA, w);
    put_beat(REQ_DATA, h);
  endtask

  task automatic run_frame_seq();
    logic [BYTE_W-1:0] w;
    logic [BYTE_W-1:0] h;
    int unsigned       pick;
    int unsigned       area;
    int unsigned       n_bytes;
    pick = $urandom_range(99);
    if (pick < 65) begin
      w = 8'($urandom_range(1, 4));
      h = 8'($urandom_range(1, 4));
    end else if (pick < 75) begin
      if ($urandom_range(1) == 1) begin
        w = 8'd0;
        h = 8'($urandom_range(255));
      end else begin
        w = 8'($urandom_range(255));
        h = 8'd0;
      end
    end else if (pick < 81) begin
      w = 8'($urandom_range(17, 255));
      h = 8'(4096 / w + 1);
    end else if (pick == 81) begin
      w = 8'd255;
      h = 8'd255;
    end else if (pick < 92) begin
      w = 8'($urandom_range(1, 255));
      h = (4096 / w > 255) ? 8'd255 : 8'(4096 / w);
    end else begin
      w = 8'($urandom_range(255));
      h = 8'($urandom_range(255));
    end
    area = 32'(w) * 32'(h);
    if ($urandom_range(19) != 0) begin
      put_beat(REQ_START, 8'($urandom_range(255)));
    end
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 4)) put_beat(REQ_DATA, 8'($urandom_range(255)));
    end
    put_header(w, h, $urandom_range(9) == 0);
    n_bytes = (area != 0 && area <= 16) ? $urandom_range(area * 6 + 2) : $urandom_range(30);
    repeat (n_bytes) begin
      if ($urandom_range(49) == 0) begin
        put_beat(REQ_START, 8'($urandom_range(255)));
      end else begin
        put_beat(REQ_DATA, 8'($urandom_range(255)));
      end
    end
  endtask

  // receiver side: random stalls, plus the long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[led_matrix_frame_receiver] ERROR");
    $finish;
  end

  initial begin
    int phase_end;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_DATA;
    data_byte_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // noise while hunting, a doubled first letter, zero width, the largest
    // accepted size, then a start event in the middle of a frame
    put_beat(REQ_DATA, 8'h00);
    put_beat(REQ_DATA, 8'hFF);
    put_beat(REQ_DATA, 8'h73);
    put_beat(REQ_DATA, 8'h73);
    put_beat(REQ_DATA, 8'h69);
    put_beat(REQ_DATA, 8'h7A);
    put_beat(REQ_DATA, 8'h65);
    put_header(8'd0, 8'd255, 1'b0);
    put_beat(REQ_DATA, 8'h5A);
    put_header(8'd64, 8'd64, 1'b0);
    put_beat(REQ_DATA, 8'h01);
    put_beat(REQ_DATA, 8'h80);
    put_beat(REQ_DATA, 8'hFE);
    put_beat(REQ_START, 8'hA5);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 46;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 46;
        end
        default: begin
          idle_pct  = 29;
          stall_pct = 29;
        end
      endcase
      phase_end = beats_sent + RANDOM_BEATS / 4;
      if (ph == 0) begin
        // fill the block behind a held receiver
        put_beat(REQ_START, 8'h00);
        put_header(8'd4, 8'd4, 1'b0);
        holds_asked++;
        repeat (48) put_beat(REQ_DATA, 8'($urandom_range(255)));
      end
      while (beats_sent < phase_end) run_frame_seq();
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (pending != 0) @(posedge clk_i);
    end

    repeat (4) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[led_matrix_frame_receiver] OK");
    end else begin
      $display("[led_matrix_frame_receiver] ERROR");
    end
    $finish;
  end

endmodule
